>>> sv/grid_overlap_copy_edge_extend_core_defines.svh
`ifndef GRID_OVERLAP_COPY_EDGE_EXTEND_CORE_DEFINES_SVH
`define GRID_OVERLAP_COPY_EDGE_EXTEND_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GOCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define GOCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/goce_pkg.sv
package goce_pkg;

    localparam int COORD_BITS    = 4;
    localparam int VALUE_BITS    = 32;
    localparam int ADDR_BITS     = 12;
    localparam int EPOCH_BITS    = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 4;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_COPY  = 2'd1,
        CMD_ACCUM = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DIMENSION  = 3'd0,
        CFG_BOX_LOW_X  = 3'd1,
        CFG_BOX_HIGH_X = 3'd2,
        CFG_BOX_LOW_Y  = 3'd3,
        CFG_BOX_HIGH_Y = 3'd4,
        CFG_BOX_LOW_Z  = 3'd5,
        CFG_BOX_HIGH_Z = 3'd6,
        CFG_EXTEND     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                        command;
        logic [COORD_BITS-1:0]       coord_x;
        logic [COORD_BITS-1:0]       coord_y;
        logic [COORD_BITS-1:0]       coord_z;
        logic signed [VALUE_BITS-1:0] sample_value;
    } t_in_req;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] read_value;
        logic                         write_landed;
        logic                         saturated;
    } t_out_res;

    // classified request handed from front to back
    typedef struct packed {
        t_cmd                         cmd;
        logic                         hit;
        logic [ADDR_BITS-1:0]         addr;
        logic signed [VALUE_BITS-1:0] sample;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> sv/goce_queue.sv
module goce_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  goce_pkg::t_op   i_push_data,
    input  logic            i_pop,
    output goce_pkg::t_op   o_pop_data,
    output goce_pkg::t_q_stat o_stat
);

    goce_pkg::t_op r_slot [2];
    logic [1:0]    r_count;
    logic [1:0]    n_count;
    logic          r_wr_ptr;
    logic          r_rd_ptr;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data   = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

endmodule

>>> sv/goce_front.sv
module goce_front #(
    parameter int DIM_X = 16,
    parameter int DIM_Y = 16,
    parameter int DIM_Z = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  goce_pkg::t_in_req                     i_in,
    output logic                                  o_in_stall,
    input  logic                                  i_cfg_valid,
    input  logic [goce_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [goce_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output logic                                  o_cfg_ready,
    input  goce_pkg::t_q_stat                     i_q_stat,
    input  logic                                  i_sweeping,
    output logic                                  o_push,
    output goce_pkg::t_op                         o_push_op
);

    localparam int CB = goce_pkg::COORD_BITS;
    localparam int AB = goce_pkg::ADDR_BITS;
    localparam logic [CB-1:0] LIM_X = CB'(DIM_X - 1);
    localparam logic [CB-1:0] LIM_Y = CB'(DIM_Y - 1);
    localparam logic [CB-1:0] LIM_Z = CB'(DIM_Z - 1);

    typedef struct packed {
        logic [CB-1:0] coord;
        logic          in_box;
        logic          in_store;
    } t_axis_res;

    logic [1:0]          r_dimension;
    logic [2:0][CB-1:0]  r_box_low;
    logic [2:0][CB-1:0]  r_box_high;
    logic                r_extend;

    logic                use_y;
    logic                use_z;
    logic                clamp_ok;
    t_axis_res           ax_x;
    t_axis_res           ax_y;
    t_axis_res           ax_z;
    logic [AB:0]         addr_full;

    function automatic t_axis_res f_axis(
        input logic [CB-1:0] c,
        input logic [CB-1:0] lo,
        input logic [CB-1:0] hi_raw,
        input logic [CB-1:0] lim,
        input logic          used,
        input logic          clamp
    );
        t_axis_res     r;
        logic [CB-1:0] hi;
        logic [CB-1:0] cc;
        logic          nonempty;
        hi       = (hi_raw < lim) ? hi_raw : lim;
        nonempty = (lo <= hi);
        cc       = c;
        if (!used) begin
            r.coord    = '0;
            r.in_box   = 1'b1;
            r.in_store = 1'b1;
        end else begin
            if (clamp && nonempty) begin
                if (cc < lo) begin
                    cc = lo;
                end
                if (cc > hi) begin
                    cc = hi;
                end
            end
            r.coord    = cc;
            r.in_box   = nonempty && (cc >= lo) && (cc <= hi);
            r.in_store = (cc <= lim);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension <= 2'd3;
            r_box_low   <= '0;
            r_box_high  <= '1;
            r_extend    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (goce_pkg::t_cfg_idx'(i_cfg_index))
                goce_pkg::CFG_DIMENSION:  r_dimension   <= i_cfg_data[1:0];
                goce_pkg::CFG_BOX_LOW_X:  r_box_low[0]  <= i_cfg_data;
                goce_pkg::CFG_BOX_HIGH_X: r_box_high[0] <= i_cfg_data;
                goce_pkg::CFG_BOX_LOW_Y:  r_box_low[1]  <= i_cfg_data;
                goce_pkg::CFG_BOX_HIGH_Y: r_box_high[1] <= i_cfg_data;
                goce_pkg::CFG_BOX_LOW_Z:  r_box_low[2]  <= i_cfg_data;
                goce_pkg::CFG_BOX_HIGH_Z: r_box_high[2] <= i_cfg_data;
                goce_pkg::CFG_EXTEND:     r_extend      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // dimension 0 behaves as 1
    assign use_y    = r_dimension[1];
    assign use_z    = (r_dimension == 2'd3);
    assign clamp_ok = (i_in.command == goce_pkg::CMD_READ) && r_extend;

    assign ax_x = f_axis(i_in.coord_x, r_box_low[0], r_box_high[0], LIM_X, 1'b1, clamp_ok);
    assign ax_y = f_axis(i_in.coord_y, r_box_low[1], r_box_high[1], LIM_Y, use_y, clamp_ok);
    assign ax_z = f_axis(i_in.coord_z, r_box_low[2], r_box_high[2], LIM_Z, use_z, clamp_ok);

    assign addr_full = (((AB+1)'(ax_z.coord) * (AB+1)'(DIM_Y) + (AB+1)'(ax_y.coord))
                        * (AB+1)'(DIM_X)) + (AB+1)'(ax_x.coord);

    always_comb begin
        o_push_op.cmd    = i_in.command;
        o_push_op.addr   = addr_full[AB-1:0];
        o_push_op.sample = i_in.sample_value;
        if (i_in.command == goce_pkg::CMD_READ) begin
            o_push_op.hit = ax_x.in_store && ax_y.in_store && ax_z.in_store;
        end else begin
            o_push_op.hit = ax_x.in_box && ax_y.in_box && ax_z.in_box;
        end
    end

    assign o_in_stall  = i_q_stat.full || i_sweeping;
    assign o_push      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

endmodule

>>> sv/goce_back.sv
module goce_back #(
    parameter int ENTRIES = 4096,
    parameter int SB      = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  goce_pkg::t_q_stat   i_q_stat,
    input  goce_pkg::t_op       i_pop_data,
    output logic                o_pop,
    output logic                o_sweeping,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output goce_pkg::t_out_res  o_out
);

    localparam int AW = $clog2(ENTRIES);
    localparam int EB = goce_pkg::EPOCH_BITS;
    localparam int WB = EB + SB;
    localparam int XB = goce_pkg::VALUE_BITS + 2;
    localparam longint SAT_HI_L = (longint'(1) << (SB - 1)) - 1;
    localparam logic signed [XB-1:0] SAT_HI = XB'(SAT_HI_L);
    localparam logic signed [XB-1:0] SAT_LO = -SAT_HI - XB'(1);

    typedef enum logic [2:0] {
        ST_SWEEP = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [AW-1:0]         r_sweep_addr;
    logic [AW-1:0]         n_sweep_addr;
    logic [EB-1:0]         r_epoch;
    logic [EB-1:0]         n_epoch;
    goce_pkg::t_op         r_op;
    goce_pkg::t_op         n_op;
    logic                  r_out_valid;
    logic                  n_out_valid;
    goce_pkg::t_out_res    r_out;
    goce_pkg::t_out_res    n_out;

    logic [WB-1:0]         r_mem [ENTRIES];
    logic [WB-1:0]         r_rd_word;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WB-1:0]         mem_wdata;
    logic                  mem_re;

    logic                  slot_free;
    logic                  tag_ok;
    logic signed [SB-1:0]  old_s;
    logic signed [XB-1:0]  wide_src;
    logic signed [XB-1:0]  wide_clip;
    logic                  clipped;
    goce_pkg::t_out_res    res;

    // entry is valid only when its tag matches the current epoch
    assign tag_ok = (r_rd_word[WB-1:SB] == r_epoch);
    assign old_s  = tag_ok ? r_rd_word[SB-1:0] : '0;

    always_comb begin
        if (r_op.cmd == goce_pkg::CMD_ACCUM) begin
            wide_src = XB'(old_s) + XB'(r_op.sample);
        end else begin
            wide_src = XB'(r_op.sample);
        end
        clipped   = 1'b0;
        wide_clip = wide_src;
        if (wide_src > SAT_HI) begin
            clipped   = 1'b1;
            wide_clip = SAT_HI;
        end else if (wide_src < SAT_LO) begin
            clipped   = 1'b1;
            wide_clip = SAT_LO;
        end
    end

    always_comb begin
        res = '0;
        case (r_op.cmd)
            goce_pkg::CMD_READ: begin
                if (r_op.hit) begin
                    res.read_value = goce_pkg::VALUE_BITS'(old_s);
                end
            end
            goce_pkg::CMD_COPY,
            goce_pkg::CMD_ACCUM: begin
                if (r_op.hit) begin
                    res.write_landed = 1'b1;
                    res.saturated    = clipped;
                end
            end
            default: ;
        endcase
    end

    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        n_epoch      = r_epoch;
        n_op         = r_op;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        mem_we       = 1'b0;
        mem_waddr    = r_op.addr[AW-1:0];
        mem_wdata    = {r_epoch, wide_clip[SB-1:0]};
        mem_re       = 1'b0;
        o_pop        = 1'b0;
        case (r_state)
            ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep_addr;
                mem_wdata = '0;
                if (r_sweep_addr == AW'(ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_sweep_addr = r_sweep_addr + AW'(1);
                end
            end
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    mem_re  = 1'b1;
                    n_op    = i_pop_data;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = res;
                    n_state     = ST_IDLE;
                    if ((r_op.cmd == goce_pkg::CMD_COPY || r_op.cmd == goce_pkg::CMD_ACCUM)
                        && r_op.hit) begin
                        mem_we = 1'b1;
                    end
                    if (r_op.cmd == goce_pkg::CMD_CLEAR) begin
                        if (r_epoch == '1) begin
                            n_epoch      = EB'(1);
                            n_sweep_addr = '0;
                            n_state      = ST_SWEEP;
                        end else begin
                            n_epoch = r_epoch + EB'(1);
                        end
                    end
                end
            end
            default: begin
                n_state      = ST_SWEEP;
                n_sweep_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_epoch      <= EB'(1);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_epoch      <= n_epoch;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_word <= r_mem[i_pop_data.addr[AW-1:0]];
        end
    end

    assign o_sweeping  = (r_state == ST_SWEEP);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> sv/grid_overlap_copy_edge_extend_core.sv
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+---------------------------------
// in       | input     | i_in_valid / o_in_stall    | i_in  (goce_pkg::t_in_req)
// out      | output    | o_out_valid / i_out_stall  | o_out (goce_pkg::t_out_res)
// cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Front classifies each request in its accept cycle into a 2-deep queue.
// Back serves one request at a time: queue pop with store read, then update and result.
// A clear bumps an 8-bit epoch; on epoch wrap the back sweeps all ENTRIES store entries.
// Reset starts the same sweep over all ENTRIES entries (4096 by default); o_in_stall is high during it.
// Results wait in an output register; while it stalls, requests enter until the queue is full.
// cfg is always ready and takes effect on the next accepted request.
module grid_overlap_copy_edge_extend_core #(
    parameter int SIZE_X      = 16,
    parameter int SIZE_Y      = 16,
    parameter int SIZE_Z      = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  goce_pkg::t_in_req                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output goce_pkg::t_out_res                 o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [goce_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [goce_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int DIM_X   = (SIZE_X < 16) ? SIZE_X : 16;
    localparam int DIM_Y   = (SIZE_Y < 16) ? SIZE_Y : 16;
    localparam int DIM_Z   = (SIZE_Z < 16) ? SIZE_Z : 16;
    localparam int ENTRIES = DIM_X * DIM_Y * DIM_Z;
    localparam int SB_EFF  = (SAMPLE_BITS < 8) ? 8 : ((SAMPLE_BITS > 32) ? 32 : SAMPLE_BITS);

    logic               push;
    goce_pkg::t_op      push_op;
    logic               pop;
    goce_pkg::t_op      pop_op;
    goce_pkg::t_q_stat  q_stat;
    logic               sweeping;

    goce_front #(
        .DIM_X (DIM_X),
        .DIM_Y (DIM_Y),
        .DIM_Z (DIM_Z)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_q_stat    (q_stat),
        .i_sweeping  (sweeping),
        .o_push      (push),
        .o_push_op   (push_op)
    );

    goce_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_op),
        .i_pop       (pop),
        .o_pop_data  (pop_op),
        .o_stat      (q_stat)
    );

    goce_back #(
        .ENTRIES (ENTRIES),
        .SB      (SB_EFF)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_pop_data  (pop_op),
        .o_pop       (pop),
        .o_sweeping  (sweeping),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

>>> sv/goce_checker.sv
`include "grid_overlap_copy_edge_extend_core_defines.svh"

module goce_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input goce_pkg::t_in_req                  i_in,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input goce_pkg::t_out_res                 o_out,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [goce_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input logic [goce_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    `GOCE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `GOCE_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out), "stalled result changed")
    `GOCE_ASSERT_NOW(a_sat_landed, i_clk, i_rst_n, o_out_valid && o_out.saturated, o_out.write_landed, "saturated without a landed write")
    `GOCE_ASSERT_NOW(a_write_no_data, i_clk, i_rst_n, o_out_valid && o_out.write_landed, o_out.read_value == 0, "write result carries read data")
    `GOCE_ASSERT_NOW(a_sweep_after_reset, i_clk, i_rst_n, $rose(i_rst_n), o_in_stall && !o_out_valid, "requests taken during store sweep")

endmodule

bind grid_overlap_copy_edge_extend_core goce_checker u_goce_checker (.*);
